// File: rtl/edcb_pkg.sv
// ----------------------------------------------------------------------------
// Edge-directed 2x corner blend package
// Widths, folded color weights and the color distance and averaging functions.
// ----------------------------------------------------------------------------
`default_nettype none

package edcb_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned RgbW    = 24;
  localparam int unsigned PixW    = 32;

  // Folded luma/chroma weights: 48*Y + 7*U + 6*V coefficients per channel.
  localparam int unsigned WeightR = 48 * 299 + 7 * (-169) + 6 * 500;
  localparam int unsigned WeightG = 48 * 587 + 7 * (-331) + 6 * (-419);
  localparam int unsigned WeightB = 48 * 114 + 7 * 500 + 6 * (-81);

  // Max distance (WeightR + WeightG + WeightB) * 255 fits in 24 bits.
  localparam int unsigned DistW   = 24;
  // Each edge sum adds four distances and one distance weighted by four.
  localparam int unsigned SumW    = DistW + 3;

  localparam int unsigned NumDist = 12;

  typedef logic [DistW-1:0] dist_t;
  typedef logic [SumW-1:0]  sum_t;
  typedef logic [RgbW-1:0]  rgb_t;
  typedef logic [ChanW-1:0] chan_t;

  function automatic chan_t absdiff(chan_t a, chan_t b);
    chan_t r;
    if (a > b) begin
      r = a - b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

  function automatic dist_t color_dist(rgb_t p, rgb_t q);
    chan_t dr;
    chan_t dg;
    chan_t db;
    int unsigned acc;
    dr  = absdiff(p[23:16], q[23:16]);
    dg  = absdiff(p[15:8], q[15:8]);
    db  = absdiff(p[7:0], q[7:0]);
    acc = WeightR * 32'(dr) + WeightG * 32'(dg) + WeightB * 32'(db);
    return acc[DistW-1:0];
  endfunction

  function automatic rgb_t avg_rgb(rgb_t p, rgb_t q);
    rgb_t    r;
    logic [ChanW:0] s;
    for (int i = 0; i < 3; i++) begin
      s = {1'b0, p[i*ChanW +: ChanW]} + {1'b0, q[i*ChanW +: ChanW]};
      r[i*ChanW +: ChanW] = s[ChanW:1];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/edge_directed_2x_corner_blend.sv
// ----------------------------------------------------------------------------
// Edge-directed 2x corner blend
// Upper-left corner output pixel of an edge-directed 2x pixel-art upscale.
// Each input beat passes the input, distance and result registers before it
// is shown at the output. Throughput: one beat per cycle; the three-stage
// pipeline only stalls when the output beat is not taken.
// Reset clears the stage valids.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_directed_2x_corner_blend (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] center_pixel_i,
  input  wire logic [23:0] up_left_pixel_i,
  input  wire logic [23:0] up_pixel_i,
  input  wire logic [23:0] left_pixel_i,
  input  wire logic [23:0] up_right_pixel_i,
  input  wire logic [23:0] right_pixel_i,
  input  wire logic [23:0] down_pixel_i,
  input  wire logic [23:0] down_left_pixel_i,
  input  wire logic [23:0] far_up_left_pixel_i,
  input  wire logic [23:0] far_up_pixel_i,
  input  wire logic [23:0] far_left_pixel_i,
  input  wire logic [23:0] far_left_up_pixel_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      out_pixel_o,
  output logic             blended_o
);

  // distance slots
  localparam int unsigned DCDl  = 0;
  localparam int unsigned DCUr  = 1;
  localparam int unsigned DUlFl = 2;
  localparam int unsigned DUlFu = 3;
  localparam int unsigned DLU   = 4;
  localparam int unsigned DLD   = 5;
  localparam int unsigned DLFlu = 6;
  localparam int unsigned DUR   = 7;
  localparam int unsigned DUFul = 8;
  localparam int unsigned DCUl  = 9;
  localparam int unsigned DCL   = 10;
  localparam int unsigned DCU   = 11;

  // stage 0: input register
  logic                 v0_q;
  logic [edcb_pkg::PixW-1:0] c_q;
  edcb_pkg::rgb_t       ul_q, u_q, l_q, ur_q, r_q, dn_q, dl_q, ful_q, fu_q, fl_q, flu_q;

  // stage 1: distance register
  logic                 v1_q;
  edcb_pkg::dist_t      dist_q [edcb_pkg::NumDist];
  edcb_pkg::dist_t      dist_d [edcb_pkg::NumDist];
  logic [edcb_pkg::PixW-1:0] c1_q;
  edcb_pkg::rgb_t       l1_q, u1_q;

  // stage 2: result register
  logic                 v2_q;
  logic [edcb_pkg::PixW-1:0] pix_q;
  logic                 blend_q;
  logic [edcb_pkg::PixW-1:0] pix_d;
  logic                 blend_d;

  logic en2, en1, en0;

  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign en0        = !v0_q || en1;
  assign in_ready_o = en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) begin
        v0_q <= in_valid_i;
      end
      if (en1) begin
        v1_q <= v0_q;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      c_q   <= center_pixel_i;
      ul_q  <= up_left_pixel_i;
      u_q   <= up_pixel_i;
      l_q   <= left_pixel_i;
      ur_q  <= up_right_pixel_i;
      r_q   <= right_pixel_i;
      dn_q  <= down_pixel_i;
      dl_q  <= down_left_pixel_i;
      ful_q <= far_up_left_pixel_i;
      fu_q  <= far_up_pixel_i;
      fl_q  <= far_left_pixel_i;
      flu_q <= far_left_up_pixel_i;
    end
  end

  always_comb begin
    dist_d[DCDl]  = edcb_pkg::color_dist(c_q[23:0], dl_q);
    dist_d[DCUr]  = edcb_pkg::color_dist(c_q[23:0], ur_q);
    dist_d[DUlFl] = edcb_pkg::color_dist(ul_q, fl_q);
    dist_d[DUlFu] = edcb_pkg::color_dist(ul_q, fu_q);
    dist_d[DLU]   = edcb_pkg::color_dist(l_q, u_q);
    dist_d[DLD]   = edcb_pkg::color_dist(l_q, dn_q);
    dist_d[DLFlu] = edcb_pkg::color_dist(l_q, flu_q);
    dist_d[DUR]   = edcb_pkg::color_dist(u_q, r_q);
    dist_d[DUFul] = edcb_pkg::color_dist(u_q, ful_q);
    dist_d[DCUl]  = edcb_pkg::color_dist(c_q[23:0], ul_q);
    dist_d[DCL]   = edcb_pkg::color_dist(c_q[23:0], l_q);
    dist_d[DCU]   = edcb_pkg::color_dist(c_q[23:0], u_q);
  end

  always_ff @(posedge clk_i) begin
    if (en1 && v0_q) begin
      dist_q <= dist_d;
      c1_q   <= c_q;
      l1_q   <= l_q;
      u1_q   <= u_q;
    end
  end

  edcb_pkg::sum_t sum_a, sum_b;
  edcb_pkg::rgb_t nb_rgb;

  always_comb begin
    sum_a = edcb_pkg::SumW'(dist_q[DCDl]) + edcb_pkg::SumW'(dist_q[DCUr])
          + edcb_pkg::SumW'(dist_q[DUlFl]) + edcb_pkg::SumW'(dist_q[DUlFu])
          + {1'b0, dist_q[DLU], 2'b00};
    sum_b = edcb_pkg::SumW'(dist_q[DLD]) + edcb_pkg::SumW'(dist_q[DLFlu])
          + edcb_pkg::SumW'(dist_q[DUR]) + edcb_pkg::SumW'(dist_q[DUFul])
          + {1'b0, dist_q[DCUl], 2'b00};
    blend_d = sum_a < sum_b;
    // tie goes to left
    nb_rgb  = (dist_q[DCL] <= dist_q[DCU]) ? l1_q : u1_q;
    pix_d[31:24] = c1_q[31:24];
    pix_d[23:0]  = blend_d ? edcb_pkg::avg_rgb(c1_q[23:0], nb_rgb) : c1_q[23:0];
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      pix_q   <= pix_d;
      blend_q <= blend_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_pixel_o = pix_q;
  assign blended_o   = blend_q;

endmodule

`default_nettype wire
